>>> design/vu_meter_pkg.sv
package vu_meter_pkg;

  localparam int unsigned SEG_COUNT = 24;

  typedef logic signed [14:0] db_t;

  localparam db_t LEVEL_FLOOR  = -15'sd10240;
  localparam db_t DB_VALID_MIN = -15'sd9984;
  localparam logic [13:0] DB_SPAN = 14'd10240;

  // round(20 * log10(2) * 65536)
  localparam logic [18:0] LOG_SCALE = 19'd394566;

  // round(65536 * log2(1 + k/16))
  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_HOLD  = 2'd1,
    CFG_FALL  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul_new;
    logic mul_old;
    logic sum;
    logic norm;
    logic interp;
    logic scale;
    logic peak;
    logic emit;
  } dp_cmd_t;

  // floor((d - floor) * SEG_COUNT / 10240), 10240 = 2^11 * 5
  function automatic logic [6:0] seg_of(db_t d);
    logic signed [15:0] off;
    logic [19:0]        prod;
    logic [8:0]         x;
    logic [17:0]        q;
    off  = 16'(d) - 16'(LEVEL_FLOOR);
    prod = 20'(off[13:0]) * 20'(SEG_COUNT);
    x    = prod[19:11];
    // x / 5 as x * 205 / 1024, exact for x below 1024
    q    = 18'(x) * 18'd205;
    return q[16:10];
  endfunction

endpackage

>>> design/vu_level_peak_hold_meter_top.sv
// vu level meter with peak hold
// input stream: s_axis_tuser is the command (0 level frame, 1 clear meter),
// s_axis_tdata carries rms_level (Q0.16) and the millisecond timestamp now_ms
// output stream: one word per input word with lit segment count, peak
// segment, peak-valid flag, smoothed level and held peak in 1/256 dBFS
// config channel: cfg_index_i selects smoothing alpha, hold time or fall
// step; always ready, write only while no word is in flight
// a level frame is walked by the sequencer after acceptance: two multiplies
// and a sum for the average, a normalize and table step, an interpolation
// multiply, a scaling multiply, the peak update and the emit into the output
// register; a clear word takes a clear step and the emit; one word is worked
// on at a time, so a new word is taken only once the last has been emitted
// the input is ready again as soon as a result sits in the output register,
// so the next word is worked on while the receiver stalls; it waits in its
// last step until the output register has been taken
// reset restores the default registers, zero level and the peak at -40 dB
module vu_level_peak_hold_meter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // rms_level, now_ms
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // lit_segments, peak_segment, peak_valid,
                                     // level_db, peak_db, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import vu_meter_pkg::*;

  dp_cmd_t    cmd;
  logic [4:0] lit_segments, peak_segment;
  logic       peak_valid;
  db_t        level_db, peak_db;

  assign cfg_ready_o = 1'b1;

  vu_meter_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  vu_meter_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .rms_level_i    (s_axis_tdata[15:0]),
    .now_ms_i       (s_axis_tdata[47:16]),
    .lit_segments_o (lit_segments),
    .peak_segment_o (peak_segment),
    .peak_valid_o   (peak_valid),
    .level_db_o     (level_db),
    .peak_db_o      (peak_db)
  );

  assign m_axis_tdata = {7'd0, peak_db, level_db, peak_valid, peak_segment, lit_segments};

endmodule

>>> design/vu_meter_ctrl.sv
module vu_meter_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output vu_meter_pkg::dp_cmd_t cmd_o
);
  import vu_meter_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MUL_NEW,
    S_MUL_OLD,
    S_SUM,
    S_NORM,
    S_INTERP,
    S_SCALE,
    S_PEAK,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_emit;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = in_cmd_i ? S_CLEAR : S_MUL_NEW;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_EMIT;
      end
      S_MUL_NEW: begin
        cmd_o.mul_new = 1'b1;
        state_d       = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        cmd_o.mul_old = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_NORM;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_INTERP;
      end
      S_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_PEAK;
      end
      S_PEAK: begin
        cmd_o.peak = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = can_emit;
        if (can_emit) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/vu_meter_dp.sv
module vu_meter_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  vu_meter_pkg::dp_cmd_t cmd_i,
  input  logic [15:0]           rms_level_i,
  input  logic [31:0]           now_ms_i,
  output logic [4:0]            lit_segments_o,
  output logic [4:0]            peak_segment_o,
  output logic                  peak_valid_o,
  output vu_meter_pkg::db_t     level_db_o,
  output vu_meter_pkg::db_t     peak_db_o
);
  import vu_meter_pkg::*;

  // configuration and meter state
  logic [15:0] alpha_q, hold_q;
  logic [13:0] fall_q;
  logic [23:0] smooth_q, smooth_d;
  db_t         peak_q, peak_d;
  logic [31:0] ptime_q, ptime_d;

  // working registers
  logic [15:0] rms_q;
  logic [31:0] now_q;
  logic [39:0] prod_a_q;
  logic [40:0] prod_b_q;
  logic [4:0]  e_q, e_d;
  logic        zero_q;
  logic [16:0] tab_lo_q, tab_diff_q;
  logic [18:0] r_q;
  logic [20:0] neg_q, neg_d;
  db_t         db_q, db_d;

  // output word
  logic [4:0]  lit_q, pk_q;
  logic        valid_q;
  db_t         level_out_q, peak_out_q;

  logic [16:0] inv_alpha;
  logic [41:0] acc;
  logic [23:0] norm_m;
  logic [4:0]  idx_lo, idx_hi;
  logic [35:0] ip;
  logic [16:0] frac;
  logic [39:0] sp;
  logic [15:0] att;
  logic [13:0] att_c;
  logic [31:0] elapsed;
  logic signed [16:0] pdiff;
  logic [6:0]  lit_raw, pk_raw, pk_lim;

  assign inv_alpha = 17'h10000 - 17'(alpha_q);
  assign acc       = 42'(prod_a_q) + 42'(prod_b_q) + 42'd32768;

  always_comb begin
    e_d = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (smooth_q[i]) begin
        e_d = 5'(i);
      end
    end
  end

  assign norm_m = smooth_q << (5'd23 - e_d);
  assign idx_lo = {1'b0, norm_m[22:19]};
  assign idx_hi = idx_lo + 5'd1;

  assign ip    = 36'(tab_diff_q) * 36'(r_q);
  assign frac  = tab_lo_q + 17'(ip >> 19);
  assign neg_d = {5'd24 - e_q, 16'd0} - 21'(frac);

  assign sp    = 40'(neg_q) * 40'(LOG_SCALE) + 40'h80_0000;
  assign att   = sp[39:24];
  assign att_c = (att > 16'(DB_SPAN)) ? DB_SPAN : att[13:0];
  assign db_d  = zero_q ? LEVEL_FLOOR : db_t'(15'd0 - {1'b0, att_c});

  assign elapsed = now_q - ptime_q;
  assign pdiff   = 17'(peak_q) - 17'($signed({1'b0, fall_q}));

  always_comb begin
    smooth_d = smooth_q;
    peak_d   = peak_q;
    ptime_d  = ptime_q;
    if (cmd_i.clear) begin
      smooth_d = '0;
      peak_d   = LEVEL_FLOOR;
      ptime_d  = '0;
    end else if (cmd_i.sum) begin
      smooth_d = acc[39:16];
    end else if (cmd_i.peak) begin
      if (db_q >= peak_q) begin
        peak_d  = db_q;
        ptime_d = now_q;
      end else if (elapsed > 32'(hold_q)) begin
        peak_d = (pdiff < 17'(LEVEL_FLOOR)) ? LEVEL_FLOOR : db_t'(pdiff[14:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 16'd6554;
      hold_q   <= 16'd600;
      fall_q   <= 14'd512;
      smooth_q <= '0;
      peak_q   <= LEVEL_FLOOR;
      ptime_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ALPHA: alpha_q <= cfg_data_i;
          CFG_HOLD:  hold_q  <= cfg_data_i;
          CFG_FALL:  fall_q  <= cfg_data_i[13:0];
          default: ;
        endcase
      end
      smooth_q <= smooth_d;
      peak_q   <= peak_d;
      ptime_q  <= ptime_d;
    end
  end

  assign lit_raw = seg_of(db_q);
  assign pk_raw  = seg_of(peak_q);
  assign pk_lim  = (pk_raw >= 7'(SEG_COUNT)) ? 7'(SEG_COUNT - 1) : pk_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rms_q <= rms_level_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.mul_new) begin
      prod_a_q <= 40'(alpha_q) * 40'({rms_q, 8'd0});
    end
    if (cmd_i.mul_old) begin
      prod_b_q <= 41'(inv_alpha) * 41'(smooth_q);
    end
    if (cmd_i.norm) begin
      e_q        <= e_d;
      zero_q     <= (smooth_q == '0);
      tab_lo_q   <= LOG2_TAB[idx_lo];
      tab_diff_q <= LOG2_TAB[idx_hi] - LOG2_TAB[idx_lo];
      r_q        <= norm_m[18:0];
    end
    if (cmd_i.interp) begin
      neg_q <= neg_d;
    end
    if (cmd_i.clear) begin
      db_q <= LEVEL_FLOOR;
    end else if (cmd_i.scale) begin
      db_q <= db_d;
    end
    if (cmd_i.emit) begin
      lit_q       <= lit_raw[4:0];
      pk_q        <= pk_lim[4:0];
      valid_q     <= (peak_q > DB_VALID_MIN);
      level_out_q <= db_q;
      peak_out_q  <= peak_q;
    end
  end

  assign lit_segments_o = lit_q;
  assign peak_segment_o = pk_q;
  assign peak_valid_o   = valid_q;
  assign level_db_o     = level_out_q;
  assign peak_db_o      = peak_out_q;

endmodule

>>> design/vu_meter_chk.sv
module vu_meter_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import vu_meter_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_peak_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10] == ($signed(m_axis_tdata[40:26]) > DB_VALID_MIN))
    else $error("peak valid flag disagrees with peak level");

endmodule

bind vu_level_peak_hold_meter_top vu_meter_chk u_chk (.*);

>>> test/vu_meter_tb_pkg.sv
package vu_meter_tb_pkg;

  typedef enum logic {
    CMD_LEVEL = 1'b0,
    CMD_CLEAR = 1'b1
  } meter_cmd_e;

endpackage

>>> test/vu_level_peak_hold_meter_checker.sv
module vu_level_peak_hold_meter_checker
  import vu_meter_pkg::*;
  import vu_meter_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [47:0] m_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int SEGS         = 24;
  localparam int FLOOR_DB     = -10240;
  localparam int SPAN_DB      = 10240;
  localparam int VALID_MIN_DB = -9984;
  localparam longint DB_PER_OCTAVE = 394566;

  localparam int LOG2_FRAC [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
  };

  // lowest bit first: lit, peak segment, peak valid, level dB, peak dB
  typedef struct packed {
    logic signed [14:0] pk;
    logic signed [14:0] lvl;
    logic               valid;
    logic [4:0]         pseg;
    logic [4:0]         lit;
  } reading_t;

  logic [23:0] avg_level;
  int          held_db;
  logic [31:0] held_ms;
  logic [15:0] alpha;
  logic [15:0] hold_ms;
  logic [13:0] fall_step;
  reading_t    reading_q[$];
  int          mismatches;
  int          results;

  function automatic int seg_of_db(int d);
    int off;
    off = d - FLOOR_DB;
    if (off < 0) off = 0;
    if (off > SPAN_DB) off = SPAN_DB;
    return off * SEGS / SPAN_DB;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [63:0] acc;
    logic [23:0] mant;
    logic [31:0] elapsed;
    logic [31:0] now;
    longint      frac;
    longint      atten;
    int          msb;
    int          idx;
    int          db;
    int          dropped;
    int          pseg;
    reading_t    want;
    reading_t    got;

    if (!rst_ni) begin
      avg_level = '0;
      held_db   = FLOOR_DB;
      held_ms   = '0;
      alpha     = 16'd6554;
      hold_ms   = 16'd600;
      fall_step = 14'd512;
      reading_q.delete();
      mismatches = 0;
      results    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ALPHA: alpha     = cfg_data_i;
          CFG_HOLD:  hold_ms   = cfg_data_i;
          CFG_FALL:  fall_step = cfg_data_i[13:0];
          default: ;
        endcase
      end

      if (s_valid_i && s_ready_i) begin
        if (meter_cmd_e'(s_user_i) == CMD_CLEAR) begin
          avg_level = '0;
          held_db   = FLOOR_DB;
          held_ms   = '0;
          db        = FLOOR_DB;
        end else begin
          now = s_data_i[47:16];
          acc = 64'(alpha) * (64'(s_data_i[15:0]) << 8)
              + (64'd65536 - 64'(alpha)) * 64'(avg_level) + 64'd32768;
          avg_level = acc[39:16];
          if (avg_level == '0) begin
            db = FLOOR_DB;
          end else begin
            msb = 23;
            while (!avg_level[msb]) msb--;
            mant  = avg_level << (23 - msb);
            idx   = int'(mant[22:19]);
            frac  = LOG2_FRAC[idx]
                  + (((LOG2_FRAC[idx + 1] - LOG2_FRAC[idx]) * longint'(mant[18:0])) >>> 19);
            atten = ((longint'(24 - msb) * 65536 - frac) * DB_PER_OCTAVE + 64'sd8388608) >>> 24;
            if (atten > SPAN_DB) atten = SPAN_DB;
            db = -int'(atten);
          end
          elapsed = now - held_ms;
          if (db >= held_db) begin
            held_db = db;
            held_ms = now;
          end else if (elapsed > 32'(hold_ms)) begin
            dropped = held_db - int'(fall_step);
            held_db = (dropped < FLOOR_DB) ? FLOOR_DB : dropped;
          end
        end
        pseg = seg_of_db(held_db);
        if (pseg > SEGS - 1) pseg = SEGS - 1;
        want.lit   = 5'(seg_of_db(db));
        want.pseg  = 5'(pseg);
        want.valid = (held_db > VALID_MIN_DB);
        want.lvl   = 15'(db);
        want.pk    = 15'(held_db);
        reading_q.push_back(want);
      end

      if (m_valid_i && m_ready_i) begin
        got = reading_t'(m_data_i[40:0]);
        if (reading_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word %0d: lit %0d pseg %0d valid %0b level %0d peak %0d",
                     results, got.lit, got.pseg, got.valid, got.lvl, got.pk);
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          if (got.lit != want.lit || got.pseg != want.pseg || got.valid != want.valid ||
              got.lvl != want.lvl || got.pk != want.pk || m_data_i[47:41] != '0) begin
            if (mismatches < 10) begin
              $display("word %0d: expected lit %0d pseg %0d valid %0b level %0d peak %0d",
                       results, want.lit, want.pseg, want.valid, want.lvl, want.pk);
              $display("  actual lit %0d pseg %0d valid %0b level %0d peak %0d fill %0h",
                       got.lit, got.pseg, got.valid, got.lvl, got.pk, m_data_i[47:41]);
            end
            mismatches++;
          end
        end
        results++;
      end

      fail_count_o <= mismatches;
      pending_o    <= reading_q.size();
      checked_o    <= results;
    end
  end

endmodule

>>> test/vu_level_peak_hold_meter_top_tb.sv
module vu_level_peak_hold_meter_top_tb;
  import vu_meter_pkg::*;
  import vu_meter_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS [6] = '{110, 110, 40, 130, 130, 130};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [47:0] s_data    = '0;
  logic        s_user    = 1'b0;
  logic        m_ready   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        s_ready;
  logic        m_valid;
  logic [47:0] m_data;
  logic        cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int src_idle_pct = 9;
  int snk_idle_pct = 49;
  int words_sent   = 0;
  int clears_sent  = 0;
  int reg_writes   = 0;
  int cycle_cnt    = 0;

  logic [31:0] clock_ms   = '0;
  logic [15:0] base_level = 16'hFFFF;

  vu_level_peak_hold_meter_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  vu_level_peak_hold_meter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_word(meter_cmd_e cmd, logic [15:0] rms, logic [31:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {now, rms};
    do @(posedge clk); while (!s_ready);
    words_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  // leaves the config valid high; set_regs lowers it once all three are in
  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic set_regs(logic [15:0] alpha, logic [15:0] hold, logic [15:0] fall);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_FALL, fall);
    cfg_valid <= 1'b0;
  endtask

  // hold the input until every outstanding word has come back
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int step_pick;
    repeat (count) begin
      step_pick = $urandom_range(99);
      if (step_pick < 85)
        clock_ms += $urandom_range(40);
      else if (step_pick < 95)
        clock_ms += $urandom_range(2000, 100);
      else if (step_pick < 99)
        clock_ms += $urandom_range(70000, 60000);
      else
        clock_ms = $urandom();
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(4))
          0:       base_level = '0;
          1:       base_level = 16'($urandom_range(255, 1));
          2:       base_level = 16'($urandom_range(39999, 256));
          3:       base_level = 16'($urandom_range(65534, 40000));
          default: base_level = 16'hFFFF;
        endcase
      end
      if ($urandom_range(99) < 3)
        send_word(CMD_CLEAR, 16'($urandom()), $urandom());
      else if ($urandom_range(99) < 6)
        send_word(CMD_LEVEL, 16'($urandom()), clock_ms);
      else
        send_word(CMD_LEVEL, base_level, clock_ms);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: rise, hold, fall after the hold time
    send_word(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_LEVEL, 16'h0000, 32'd0);
    send_word(CMD_LEVEL, 16'hFFFF, 32'd1);
    send_word(CMD_LEVEL, 16'hFFFF, 32'd2);
    send_word(CMD_LEVEL, 16'h0000, 32'd3);
    send_word(CMD_LEVEL, 16'h0000, 32'd700);
    send_word(CMD_LEVEL, 16'h0000, 32'd701);
    // peak taken just before the timestamp wraps
    send_word(CMD_CLEAR, 16'h0000, 32'd0);
    send_word(CMD_LEVEL, 16'hFFFF, 32'hFFFF_FFF8);
    send_word(CMD_LEVEL, 16'h0000, 32'd4);
    send_word(CMD_LEVEL, 16'h0000, 32'd700);
    drain();

    // fastest smoothing, no hold, oversized fall step
    set_regs(16'hFFFF, 16'h0000, 16'hFFFF);
    send_word(CMD_LEVEL, 16'hFFFF, 32'd100);
    send_word(CMD_LEVEL, 16'hFFFF, 32'd100);
    send_word(CMD_LEVEL, 16'h0000, 32'd100);
    send_word(CMD_LEVEL, 16'h0000, 32'd101);
    send_word(CMD_LEVEL, 16'h0001, 32'd102);
    send_word(CMD_LEVEL, 16'h8000, 32'd103);
    drain();

    // zero weight keeps the average where it is
    set_regs(16'h0000, 16'h0000, 16'd10240);
    send_word(CMD_LEVEL, 16'hFFFF, 32'd104);
    send_word(CMD_LEVEL, 16'h0000, 32'd105);
    drain();

    clock_ms = $urandom();
    for (int ph = 0; ph < 6; ph++) begin
      src_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 49 : 0;
      snk_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 9 : 0;
      case (ph)
        0: set_regs(16'd1, 16'd0, 16'd1);
        1: set_regs(16'hFFFF, 16'hFFFF, 16'd10240);
        2: set_regs(16'd0, 16'd300, 16'd512);
        3: set_regs(16'($urandom_range(65535, 1)), 16'($urandom_range(2000)),
                    16'($urandom_range(16383)));
        4: set_regs(16'h8000, 16'd600, 16'hFFFF);
        default: set_regs(16'd6554, 16'd600, 16'd512);
      endcase
      run_random(PHASE_WORDS[ph]);
      drain();
    end

    $display("sent %0d words (%0d clears) with %0d register writes over three idle patterns",
             words_sent, clears_sent, reg_writes);
    $display("compared %0d results, %0d mismatches", checked, fail_count);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
